/* hw/rtl/bbsa_pkg.sv */
// Package of the bucketed bitmap slot allocator: request kinds, result
// status codes, controller states and the register reset value.
// Depends on nothing; the top level and the checker import it.
package bbsa_pkg;

    // Request kinds carried in the kind field.
    localparam logic KIND_ALLOC = 1'b0;
    localparam logic KIND_FREE  = 1'b1;

    // Reset value of slots_per_bucket.
    localparam logic [6:0] CFG_SLOTS_RESET = 7'd64;

    // Result status codes.
    typedef enum logic [1:0] {
        ST_ALLOC   = 2'd0,
        ST_FREED   = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // Controller states.
    typedef enum logic [2:0] {
        S_IDLE = 3'd0,
        S_PICK = 3'd1,
        S_MOD  = 3'd2,
        S_UPD  = 3'd3,
        S_DONE = 3'd4
    } t_state;

endpackage

/* hw/rtl/bbsa_ffs.sv */
// Find-first-set encoder: index of the lowest set bit of a vector.
// Depends on nothing; instanced by the allocator top level.
module bbsa_ffs #(
    parameter int W = 64
) (
    input  logic [W-1:0]                  i_vec,
    output logic [((W > 1) ? $clog2(W) : 1)-1:0] o_idx,
    output logic                          o_any
);
    localparam int IW = (W > 1) ? $clog2(W) : 1;

    logic [W-1:0] iso;

    // Isolate the lowest set bit with a two's complement add.
    assign iso   = i_vec & (~i_vec + W'(1));
    assign o_any = |i_vec;

    // Encode the one-hot word: each index bit ORs the positions that carry it.
    always_comb begin
        o_idx = '0;
        for (int k = 0; k < IW; k++) begin
            for (int i = 0; i < W; i++) begin
                if (((i >> k) & 1) == 1) begin
                    o_idx[k] = o_idx[k] | iso[i];
                end
            end
        end
    end

endmodule

/* hw/rtl/bucketed_bitmap_slot_allocator_unit.sv */
// Top level of the bucketed bitmap slot allocator: controller, bitmap memory
// and per-bucket lowest-free summary. Depends on bbsa_pkg and bbsa_ffs.
//
//   channel   direction  handshake               payload
//   in        input      i_in_valid / o_in_stall i_kind, i_bucket, i_slot
//   out       output     o_out_valid / i_out_stall o_status, o_got_bucket, o_got_slot
//   cfg       input      i_cfg_wr_en             i_cfg_wr_data (slots_per_bucket)
//
// An item that rewrites a bitmap (a grant from an open bucket or a valid free) passes
// through accept with summary compare, bucket pick and memory read, bitmap modify
// and write-back, summary update with result hand-off. Opening a bucket, pool full
// and invalid free skip the modify step.
// The steps follow from the registered read of the bitmap memory and
// the read-modify-write of one entry per item; a stalled output holds the item.
// Reset is synchronous and needs no clearing pass: a bucket's bitmap is
// written when it opens, and only open buckets are read.
// An item may be accepted while the previous result still waits in the
// output register.
module bucketed_bitmap_slot_allocator_unit #(
    parameter int MAX_BUCKETS = 64,
    parameter int SLOTS_MAX   = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // Request channel.
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic       i_kind,
    input  logic [5:0] i_bucket,
    input  logic [5:0] i_slot,
    // Result channel.
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [1:0] o_status,
    output logic [5:0] o_got_bucket,
    output logic [5:0] o_got_slot,
    // Configuration write.
    input  logic       i_cfg_wr_en,
    input  logic [6:0] i_cfg_wr_data
);
    import bbsa_pkg::*;

    localparam int BW = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
    localparam int OW = $clog2(MAX_BUCKETS + 1);
    localparam int SW = (SLOTS_MAX > 1) ? $clog2(SLOTS_MAX) : 1;
    localparam int LW = $clog2(SLOTS_MAX + 1);

    // Control registers.
    t_state            r_state, n_state;
    logic [OW-1:0]     r_open, n_open;
    logic [6:0]        r_cfg;
    logic              r_ovalid, n_ovalid;

    // Payload registers.
    logic              r_kind, n_kind;
    logic [5:0]        r_bucket, n_bucket;
    logic [5:0]        r_slot, n_slot;
    logic [MAX_BUCKETS-1:0] r_hit, n_hit;
    logic [BW-1:0]     r_addr, n_addr;
    logic [SLOTS_MAX-1:0] r_new, n_new;
    logic              r_upd_low, n_upd_low;
    t_status           r_status, n_status;
    logic [BW-1:0]     r_gb, n_gb;
    logic [SW-1:0]     r_gs, n_gs;
    t_status           r_ostatus;
    logic [BW-1:0]     r_ogb;
    logic [SW-1:0]     r_ogs;

    // Bitmap memory and per-bucket index of the lowest set bit.
    logic [SLOTS_MAX-1:0] mem [MAX_BUCKETS];
    logic [SLOTS_MAX-1:0] r_rdata;
    logic [LW-1:0]     r_low [MAX_BUCKETS];

    logic              mem_we, mem_re;
    logic [BW-1:0]     mem_waddr, mem_raddr;
    logic [SLOTS_MAX-1:0] mem_wdata;
    logic              low_we;
    logic [LW-1:0]     low_val;
    logic              out_load;

    logic              in_acc, out_free;
    logic [6:0]        lim7;
    logic [LW-1:0]     lim;
    logic [SLOTS_MAX-1:0] lim_mask;
    logic [MAX_BUCKETS-1:0] hit_now;
    logic [BW-1:0]     hit_idx;
    logic              hit_any;
    logic [SW-1:0]     rd_idx;
    logic [SW-1:0]     new_idx;
    logic              new_any;
    logic              free_ok, pool_full, pick_rmw;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign out_free   = !r_ovalid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    // Effective slot limit: zero acts as one, values above the maximum clamp.
    always_comb begin
        if (r_cfg == 7'd0) begin
            lim7 = 7'd1;
        end else if (r_cfg > 7'(SLOTS_MAX)) begin
            lim7 = 7'(SLOTS_MAX);
        end else begin
            lim7 = r_cfg;
        end
        lim = LW'(lim7);
    end

    // Mask of the usable slots.
    always_comb begin
        for (int i = 0; i < SLOTS_MAX; i++) begin
            lim_mask[i] = (LW'(i) < lim);
        end
    end

    // A bucket can grant when it is open and its lowest free slot is usable.
    always_comb begin
        for (int b = 0; b < MAX_BUCKETS; b++) begin
            hit_now[b] = (OW'(b) < r_open) && (r_low[b] < lim);
        end
    end

    bbsa_ffs #(.W(MAX_BUCKETS)) u_hit_ffs (
        .i_vec (r_hit),
        .o_idx (hit_idx),
        .o_any (hit_any)
    );

    bbsa_ffs #(.W(SLOTS_MAX)) u_slot_ffs (
        .i_vec (r_rdata),
        .o_idx (rd_idx),
        .o_any ()
    );

    bbsa_ffs #(.W(SLOTS_MAX)) u_low_ffs (
        .i_vec (r_new),
        .o_idx (new_idx),
        .o_any (new_any)
    );

    // An empty bitmap records SLOTS_MAX as its lowest free index.
    assign low_val = new_any ? LW'(new_idx) : LW'(SLOTS_MAX);

    assign free_ok   = ({1'b0, r_bucket} < 7'(r_open)) && ({1'b0, r_slot} < lim7);
    assign pool_full = (r_open == OW'(MAX_BUCKETS));
    assign pick_rmw  = (r_kind == KIND_ALLOC) ? hit_any : free_ok;

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) n_state = S_PICK;
            end
            S_PICK: begin
                n_state = pick_rmw ? S_MOD : S_UPD;
            end
            S_MOD: begin
                n_state = S_UPD;
            end
            S_UPD, S_DONE: begin
                n_state = out_free ? S_IDLE : S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Datapath controls and next values.
    always_comb begin
        n_kind    = r_kind;
        n_bucket  = r_bucket;
        n_slot    = r_slot;
        n_hit     = r_hit;
        n_addr    = r_addr;
        n_new     = r_new;
        n_upd_low = r_upd_low;
        n_status  = r_status;
        n_gb      = r_gb;
        n_gs      = r_gs;
        n_open    = r_open;
        mem_we    = 1'b0;
        mem_re    = 1'b0;
        mem_waddr = r_addr;
        mem_raddr = r_addr;
        mem_wdata = r_new;
        low_we    = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_kind   = i_kind;
                    n_bucket = i_bucket;
                    n_slot   = i_slot;
                    n_hit    = hit_now;
                end
            end
            S_PICK: begin
                n_gb      = '0;
                n_gs      = '0;
                n_upd_low = 1'b0;
                if (r_kind == KIND_ALLOC) begin
                    if (hit_any) begin
                        // Grant from the first open bucket with a usable slot.
                        n_addr    = hit_idx;
                        mem_raddr = hit_idx;
                        mem_re    = 1'b1;
                        n_gb      = hit_idx;
                        n_status  = ST_ALLOC;
                        n_upd_low = 1'b1;
                    end else if (!pool_full) begin
                        // Open the next bucket and grant its slot 0.
                        n_addr    = BW'(r_open);
                        n_new     = lim_mask & ~SLOTS_MAX'(1);
                        mem_waddr = BW'(r_open);
                        mem_wdata = lim_mask & ~SLOTS_MAX'(1);
                        mem_we    = 1'b1;
                        n_open    = r_open + OW'(1);
                        n_gb      = BW'(r_open);
                        n_status  = ST_ALLOC;
                        n_upd_low = 1'b1;
                    end else begin
                        n_status = ST_FULL;
                    end
                end else begin
                    if (free_ok) begin
                        n_addr    = BW'(r_bucket);
                        mem_raddr = BW'(r_bucket);
                        mem_re    = 1'b1;
                        n_status  = ST_FREED;
                        n_upd_low = 1'b1;
                    end else begin
                        n_status = ST_INVALID;
                    end
                end
            end
            S_MOD: begin
                // Clear the lowest set bit on a grant, set the named bit on a free.
                if (r_kind == KIND_ALLOC) begin
                    n_new = r_rdata & (r_rdata - SLOTS_MAX'(1));
                    n_gs  = rd_idx;
                end else begin
                    n_new = r_rdata | (SLOTS_MAX'(1) << SW'(r_slot));
                end
                mem_wdata = n_new;
                mem_we    = 1'b1;
            end
            S_UPD: begin
                low_we   = r_upd_low;
                out_load = out_free;
            end
            S_DONE: begin
                out_load = out_free;
            end
            default: begin
            end
        endcase
        if (out_load) begin
            n_ovalid = 1'b1;
        end else if (!i_out_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_open   <= '0;
            r_cfg    <= CFG_SLOTS_RESET;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_open   <= n_open;
            r_ovalid <= n_ovalid;
            if (i_cfg_wr_en) r_cfg <= i_cfg_wr_data;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_kind    <= n_kind;
        r_bucket  <= n_bucket;
        r_slot    <= n_slot;
        r_hit     <= n_hit;
        r_addr    <= n_addr;
        r_new     <= n_new;
        r_upd_low <= n_upd_low;
        r_status  <= n_status;
        r_gb      <= n_gb;
        r_gs      <= n_gs;
        if (out_load) begin
            r_ostatus <= r_status;
            r_ogb     <= r_gb;
            r_ogs     <= r_gs;
        end
    end

    // Bitmap memory, one write and one registered read.
    always_ff @(posedge i_clk) begin
        if (mem_we) mem[mem_waddr] <= mem_wdata;
        if (mem_re) r_rdata <= mem[mem_raddr];
    end

    // Summary of the lowest set bit of each written bitmap.
    always_ff @(posedge i_clk) begin
        if (low_we) r_low[r_addr] <= low_val;
    end

    assign o_out_valid  = r_ovalid;
    assign o_status     = r_ostatus;
    assign o_got_bucket = 6'(r_ogb);
    assign o_got_slot   = 6'(r_ogs);

endmodule

/* hw/rtl/bbsa_checker.sv */
// Port-level checker of the bucketed bitmap slot allocator, bound to the top
// level. Depends on bbsa_pkg for the status codes.
module bbsa_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_valid,
    input logic       o_in_stall,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [1:0] o_status,
    input logic [5:0] o_got_bucket,
    input logic [5:0] o_got_slot
);
    import bbsa_pkg::*;

    // A stalled result holds its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_status)
            && $stable(o_got_bucket) && $stable(o_got_slot))
        else $error("stalled result changed");

    // Reset leaves the block ready with no result pending.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_stall && !o_out_valid)
        else $error("block not idle after reset");

    // Only one item is in work at a time.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("second item accepted while one is in work");

    // Results other than a grant carry zero bucket and slot.
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_status != ST_ALLOC) |-> (o_got_bucket == 6'd0)
            && (o_got_slot == 6'd0))
        else $error("non-grant result with nonzero fields");

endmodule

bind bucketed_bitmap_slot_allocator_unit bbsa_checker u_bbsa_checker (.*);
